FILE: rtl/core/acl_pkg.sv
// Package for the adaptive concurrency limiter: widths, command codes,
// register indexes, reset values and the controller/datapath link types.
// No dependencies.
`timescale 1ns / 1ps

package acl_pkg;

  // Field widths
  localparam int LIMIT_W = 10;
  localparam int RATIO_W = 9;
  localparam int COUNT_W = 16;
  localparam int TIME_W  = 32;
  localparam int PCT_W   = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Derived datapath widths
  localparam int NUM_W  = COUNT_W + PCT_W;        // fails * 100
  localparam int DEN_W  = COUNT_W + PCT_W - 1;    // total shifted up by PCT_W - 1
  localparam int PROD_W = LIMIT_W + RATIO_W;      // limit * ratio
  localparam int SCALED_W = PROD_W - 8;           // floor(product / 256)
  localparam int DIV_STEPS = PCT_W;

  // Saturation points
  localparam logic [LIMIT_W-1:0] LIMIT_MAX   = 10'd1023;
  localparam logic [COUNT_W-1:0] SAMPLES_MAX = 16'd65535;
  localparam logic [NUM_W-1:0]   PCT_SCALE   = 23'd100;

  // Item commands
  localparam logic [1:0] CMD_CHECK   = 2'd0;
  localparam logic [1:0] CMD_START   = 2'd1;
  localparam logic [1:0] CMD_FINISH  = 2'd2;
  localparam logic [1:0] CMD_OUTCOME = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LIMIT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LIMIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_RATIO  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_RATIO  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_THR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SEC  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_PCT    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_PCT    = 3'd7;

  // Register reset values
  localparam logic [LIMIT_W-1:0] RST_MAX_LIMIT  = 10'd64;
  localparam logic [LIMIT_W-1:0] RST_MIN_LIMIT  = 10'd1;
  localparam logic [RATIO_W-1:0] RST_SLOW_RATIO = 9'd204;
  localparam logic [RATIO_W-1:0] RST_FAST_RATIO = 9'd128;
  localparam logic [COUNT_W-1:0] RST_SAMPLE_THR = 16'd10;
  localparam logic [COUNT_W-1:0] RST_WINDOW_SEC = 16'd3;
  localparam logic [PCT_W-1:0]   RST_KEEP_PCT   = 7'd10;
  localparam logic [PCT_W-1:0]   RST_SLOW_PCT   = 7'd40;

  typedef struct packed {
    logic [LIMIT_W-1:0] max_limit;
    logic [LIMIT_W-1:0] min_limit;
    logic [RATIO_W-1:0] slow_ratio;
    logic [RATIO_W-1:0] fast_ratio;
    logic [COUNT_W-1:0] sample_threshold;
    logic [COUNT_W-1:0] window_seconds;
    logic [PCT_W-1:0]   keep_percent;
    logic [PCT_W-1:0]   slow_percent;
  } cfg_regs_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_in;
    logic exec;
    logic div_step;
    logic scale;
    logic raise;
    logic clamp;
    logic load_out;
  } ctl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic close;
    logic pct_zero;
    logic pct_keep;
  } dp_status_t;

endpackage

FILE: rtl/core/acl_if.sv
// Channel interfaces of the adaptive concurrency limiter: item input,
// result output and register write. Depends on acl_pkg.
`timescale 1ns / 1ps

interface acl_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic       success;
  logic [acl_pkg::TIME_W-1:0] now_seconds;

  modport source (output valid, cmd, success, now_seconds, input ready);
  modport sink   (input valid, cmd, success, now_seconds, output ready);
endinterface

interface acl_out_if;
  logic       valid;
  logic       ready;
  logic       may_pop;
  logic [acl_pkg::LIMIT_W-1:0] current_limit;
  logic [acl_pkg::LIMIT_W-1:0] in_flight;

  modport source (output valid, may_pop, current_limit, in_flight, input ready);
  modport sink   (input valid, may_pop, current_limit, in_flight, output ready);
endinterface

interface acl_cfg_if;
  logic valid;
  logic ready;
  logic [acl_pkg::CFG_IDX_W-1:0]  index;
  logic [acl_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/acl_datapath.sv
// Datapath of the adaptive concurrency limiter: registers, counters,
// window logic, shift-subtract percentage divider and limit scaling.
// Depends on acl_pkg; driven by acl_ctrl through ctl_cmd_t.
`timescale 1ns / 1ps

module acl_datapath (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [acl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [acl_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [1:0] cmd,
  input  logic       success,
  input  logic [acl_pkg::TIME_W-1:0] now_seconds,
  input  acl_pkg::ctl_cmd_t   ctl,
  output acl_pkg::dp_status_t status,
  output logic may_pop,
  output logic [acl_pkg::LIMIT_W-1:0] current_limit,
  output logic [acl_pkg::LIMIT_W-1:0] in_flight
);

  acl_pkg::cfg_regs_t regs;

  logic [acl_pkg::LIMIT_W-1:0] limit_now;
  logic [acl_pkg::LIMIT_W-1:0] sends_active;
  logic [acl_pkg::COUNT_W-1:0] win_total;
  logic [acl_pkg::COUNT_W-1:0] win_fails;
  logic [acl_pkg::TIME_W-1:0]  win_start;
  logic                        win_open;

  // Latched item
  logic [1:0]                  item_cmd;
  logic                        item_success;
  logic [acl_pkg::TIME_W-1:0]  item_now;

  // Divider and scaling registers
  logic                        close_flag;
  logic [acl_pkg::NUM_W-1:0]   rem;
  logic [acl_pkg::DEN_W-1:0]   den_sh;
  logic [acl_pkg::PCT_W-1:0]   quo;
  logic [acl_pkg::PROD_W-1:0]  prod;

  // Window update terms
  logic [acl_pkg::COUNT_W-1:0] total_inc;
  logic [acl_pkg::COUNT_W-1:0] fails_inc;
  logic [acl_pkg::TIME_W-1:0]  start_eff;
  logic [acl_pkg::TIME_W-1:0]  elapsed;
  logic                        close_c;

  // Divider step terms
  logic                        div_ge;

  // Scaling terms
  logic [acl_pkg::RATIO_W-1:0]  ratio_sel;
  logic [acl_pkg::SCALED_W-1:0] scaled;
  logic [acl_pkg::SCALED_W-1:0] floored;

  // Window counters after this outcome, and the close decision
  always_comb begin
    total_inc = (win_total < acl_pkg::SAMPLES_MAX) ? win_total + 1'b1 : win_total;
    fails_inc = (!item_success && win_fails < acl_pkg::SAMPLES_MAX) ?
                win_fails + 1'b1 : win_fails;
    start_eff = win_open ? win_start : item_now;
    elapsed   = item_now - start_eff;
    close_c   = (total_inc >= regs.sample_threshold) ||
                ((item_now >= start_eff) &&
                 (elapsed > {{(acl_pkg::TIME_W-acl_pkg::COUNT_W){1'b0}}, regs.window_seconds}));
  end

  assign div_ge = (rem >= {1'b0, den_sh});

  // Pick the ratio from the percentage band; clamp the scaled limit
  always_comb begin
    ratio_sel = (quo <= regs.slow_percent) ? regs.slow_ratio : regs.fast_ratio;
    scaled    = prod[acl_pkg::PROD_W-1:8];
    floored   = (scaled < {1'b0, regs.min_limit}) ? {1'b0, regs.min_limit} : scaled;
  end

  assign status.close    = close_flag;
  assign status.pct_zero = (quo == '0);
  assign status.pct_keep = (quo <= regs.keep_percent);

  // Register writes and limiter state
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.max_limit        <= acl_pkg::RST_MAX_LIMIT;
      regs.min_limit        <= acl_pkg::RST_MIN_LIMIT;
      regs.slow_ratio       <= acl_pkg::RST_SLOW_RATIO;
      regs.fast_ratio       <= acl_pkg::RST_FAST_RATIO;
      regs.sample_threshold <= acl_pkg::RST_SAMPLE_THR;
      regs.window_seconds   <= acl_pkg::RST_WINDOW_SEC;
      regs.keep_percent     <= acl_pkg::RST_KEEP_PCT;
      regs.slow_percent     <= acl_pkg::RST_SLOW_PCT;
      limit_now    <= acl_pkg::RST_MAX_LIMIT;
      sends_active <= '0;
      win_total    <= '0;
      win_fails    <= '0;
      win_start    <= '0;
      win_open     <= 1'b0;
      close_flag   <= 1'b0;
    end else begin
      // Decode register writes
      if (cfg_we) begin
        unique case (cfg_index)
          acl_pkg::REG_MAX_LIMIT:  regs.max_limit  <= cfg_data[acl_pkg::LIMIT_W-1:0];
          acl_pkg::REG_MIN_LIMIT:  regs.min_limit  <= cfg_data[acl_pkg::LIMIT_W-1:0];
          acl_pkg::REG_SLOW_RATIO: regs.slow_ratio <= cfg_data[acl_pkg::RATIO_W-1:0];
          acl_pkg::REG_FAST_RATIO: regs.fast_ratio <= cfg_data[acl_pkg::RATIO_W-1:0];
          acl_pkg::REG_SAMPLE_THR: regs.sample_threshold <= cfg_data;
          acl_pkg::REG_WINDOW_SEC: regs.window_seconds   <= cfg_data;
          acl_pkg::REG_KEEP_PCT:   regs.keep_percent <= cfg_data[acl_pkg::PCT_W-1:0];
          acl_pkg::REG_SLOW_PCT:   regs.slow_percent <= cfg_data[acl_pkg::PCT_W-1:0];
          default: ;
        endcase
      end

      // Apply the item to the counters and the window
      if (ctl.exec) begin
        close_flag <= 1'b0;
        case (item_cmd)
          acl_pkg::CMD_START: begin
            if (sends_active < acl_pkg::LIMIT_MAX) sends_active <= sends_active + 1'b1;
          end
          acl_pkg::CMD_FINISH: begin
            if (sends_active != '0) sends_active <= sends_active - 1'b1;
          end
          acl_pkg::CMD_OUTCOME: begin
            win_open   <= 1'b1;
            close_flag <= close_c;
            if (close_c) begin
              win_total <= '0;
              win_fails <= '0;
              win_start <= item_now;
            end else begin
              win_total <= total_inc;
              win_fails <= fails_inc;
              win_start <= start_eff;
            end
          end
          default: ;
        endcase
      end

      // Additive increase
      if (ctl.raise) begin
        if (limit_now != regs.max_limit && limit_now < acl_pkg::LIMIT_MAX)
          limit_now <= limit_now + 1'b1;
      end

      // Multiplicative decrease, floored at min and saturated
      if (ctl.clamp) begin
        if (limit_now != regs.min_limit) begin
          limit_now <= (floored > {1'b0, acl_pkg::LIMIT_MAX}) ?
                       acl_pkg::LIMIT_MAX : floored[acl_pkg::LIMIT_W-1:0];
        end else if (regs.min_limit == '0) begin
          limit_now <= acl_pkg::LIMIT_W'(1);
        end
      end
    end
  end

  // Payload registers: item latch, divider, product, result word
  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      item_cmd     <= cmd;
      item_success <= success;
      item_now     <= now_seconds;
    end

    // Load the divider with fails * 100 over the shifted total
    if (ctl.exec) begin
      rem    <= {{acl_pkg::PCT_W{1'b0}}, fails_inc} * acl_pkg::PCT_SCALE;
      den_sh <= {total_inc, {(acl_pkg::PCT_W-1){1'b0}}};
      quo    <= '0;
    end

    // One quotient bit per step
    if (ctl.div_step) begin
      if (div_ge) rem <= rem - {1'b0, den_sh};
      quo    <= {quo[acl_pkg::PCT_W-2:0], div_ge};
      den_sh <= den_sh >> 1;
    end

    if (ctl.scale) begin
      prod <= acl_pkg::PROD_W'(limit_now) * acl_pkg::PROD_W'(ratio_sel);
    end

    if (ctl.load_out) begin
      may_pop       <= (limit_now > sends_active);
      current_limit <= limit_now;
      in_flight     <= sends_active;
    end
  end

endmodule

FILE: rtl/core/acl_ctrl.sv
// Controller of the adaptive concurrency limiter: sequences one item
// through update, divide, decide and scale, and owns the handshakes.
// Depends on acl_pkg.
`timescale 1ns / 1ps

module acl_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  acl_pkg::dp_status_t status,
  output acl_pkg::ctl_cmd_t   ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_CHECK,
    S_DIV,
    S_DECIDE,
    S_CLAMP,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic [$clog2(acl_pkg::DIV_STEPS)-1:0] div_cnt;
  logic out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // Decode commands and next state
  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load_in = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec   = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = status.close ? S_DIV : S_DONE;
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        if (div_cnt == ($clog2(acl_pkg::DIV_STEPS))'(acl_pkg::DIV_STEPS - 1))
          state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (status.pct_zero) begin
          ctl.raise  = 1'b1;
          state_next = S_DONE;
        end else if (status.pct_keep) begin
          state_next = S_DONE;
        end else begin
          ctl.scale  = 1'b1;
          state_next = S_CLAMP;
        end
      end
      S_CLAMP: begin
        ctl.clamp  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State, step counter and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DIV) div_cnt <= div_cnt + 1'b1;
      else                div_cnt <= '0;
      if (ctl.load_out)   out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // An accepted word always moves on to the update step
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_EXEC))
    else $error("accepted word did not reach update step");

  // Loading the result register raises valid
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    ctl.load_out |=> out_valid)
    else $error("result load did not raise valid");

  // Never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.load_out |-> (!out_valid || out_ready))
    else $error("result overwritten before taken");

  // Increase and decrease are never commanded together
  a_one_step: assert property (@(posedge clk) disable iff (rst)
    !(ctl.raise && (ctl.scale || ctl.clamp)))
    else $error("increase and decrease in one window");

  // Divider counter stays within the quotient width
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |->
      (div_cnt <= ($clog2(acl_pkg::DIV_STEPS))'(acl_pkg::DIV_STEPS - 1)))
    else $error("divider ran past its steps");

endmodule

FILE: rtl/core/adaptive_concurrency_limiter_unit.sv
// An item is taken in the idle state and passes the update and check states; a
// check, start, finish or outcome that keeps the window open then goes to done,
// which loads the result word; an outcome closing a window first runs the 7-step
// divider, the decision and any scaling. No new item is taken before the result
// word is loaded, and done waits while the previous word waits for the receiver.
// Reset (rst, synchronous): registers take their defaults, the limit becomes 64,
// counters clear and the window is closed; no clearing pass is needed.
`timescale 1ns / 1ps

module adaptive_concurrency_limiter_unit (
  input  logic clk,
  input  logic rst,
  acl_in_if.sink    item_in,
  acl_out_if.source result_out,
  acl_cfg_if.sink   cfg
);

  acl_pkg::ctl_cmd_t   ctl;
  acl_pkg::dp_status_t status;
  logic in_ready;
  logic out_valid;

  // Register writes are always taken
  assign cfg.ready      = 1'b1;
  assign item_in.ready  = in_ready;
  assign result_out.valid = out_valid;

  acl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_in.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (result_out.ready),
    .status    (status),
    .ctl       (ctl)
  );

  acl_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg.valid),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .cmd           (item_in.cmd),
    .success       (item_in.success),
    .now_seconds   (item_in.now_seconds),
    .ctl           (ctl),
    .status        (status),
    .may_pop       (result_out.may_pop),
    .current_limit (result_out.current_limit),
    .in_flight     (result_out.in_flight)
  );

endmodule
